>>> src/sclf_pkg.sv
package sclf_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int ELNK_W = EDGE_W + 1;
  localparam int CNT_W  = NODE_W + 1;
  localparam int LOOP_W = 7;
  localparam int LCNT_W = 6;

  localparam logic [ELNK_W-1:0] NO_EDGE  = ELNK_W'(MAX_EDGES);
  localparam logic [CNT_W-1:0]  NODE_MAX = CNT_W'(MAX_NODES);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_EDGE_ERR = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_RSVD     = 2'd3
  } kind_t;

  // one suspended DFS call
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ELNK_W-1:0] edge_ptr;
    logic [NODE_W-1:0] low;
    logic [NODE_W-1:0] ord;
  } frame_t;

endpackage

>>> src/sclf_ram.sv
module sclf_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/strongly_connected_loop_finder.sv
// Beats: clear, add edge (a new list, or an append to the tail of one), error report and query.
// A run scans node ids in order, enters each unvisited node, follows each of its edges,
// closes each component and marks the nodes of each loop.
// One beat in flight at a time; a result may wait in the output register while the next
// beat is taken. Synchronous active-low reset clears control state only; edge lists start
// empty through per-node valid flops, no clearing pass.
module strongly_connected_loop_finder
  import sclf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,     // node_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [5:0] block_a, [11:6] block_b
  input  logic [1:0]  in_tuser,      // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [6:0] loop_a, [13:7] loop_b, [14] same_loop,
                                     // [20:15] loop_count
  output logic [1:0]  out_tuser      // [1:0] kind
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD_NEW, ST_ADD_RD, ST_ADD_LINK, ST_ADD_TAIL,
    ST_ROOT, ST_ENTER, ST_LOOP, ST_EDGE, ST_ORDCHK,
    ST_POP, ST_POP_RD, ST_POP_DONE, ST_LW, ST_LW_RD,
    ST_FPOP, ST_FRD, ST_Q_A, ST_Q_B, ST_Q_C, ST_EMIT
  } state_t;

  state_t st_r;

  logic [CNT_W-1:0]   node_count_r;
  logic [CNT_W-1:0]   n_use;
  logic [NODE_W-1:0]  a_r, b_r;
  logic [MAX_NODES-1:0] fvalid_r, visited_r, onstk_r, loopv_r;
  logic [ELNK_W-1:0]  etot_r;
  logic [CNT_W-1:0]   vc_r, cc_r, comp_r;
  logic [LCNT_W-1:0]  lf_r;
  logic [CNT_W-1:0]   r_r, fsp_r, nsp_r, base_r, k_r;
  logic               active_r, pop1_r, many_r;
  logic [NODE_W-1:0]  v_r, low_r, ord_r, ent_r;
  logic [ELNK_W-1:0]  e_r;
  kind_t              res_kind_r;
  logic [LOOP_W-1:0]  res_la_r, res_lb_r;
  logic               res_same_r;

  logic               out_valid_r;
  logic [23:0]        out_data_r;
  kind_t              out_kind_r;

  // memory ports
  logic                first_we, last_we, tgt_we, nxt_we, ord_we, loop_we, nstk_we, frm_we;
  logic [NODE_W-1:0]   first_addr, last_addr, ord_addr, loop_addr, nstk_addr, frm_addr;
  logic [EDGE_W-1:0]   tgt_addr, nxt_addr;
  logic [EDGE_W-1:0]   first_wd, last_wd, first_rd, last_rd;
  logic [NODE_W-1:0]   tgt_wd, tgt_rd, ord_wd, ord_rd, nstk_wd, nstk_rd;
  logic [ELNK_W-1:0]   nxt_wd, nxt_rd;
  logic [LOOP_W-1:0]   loop_wd, loop_rd;
  frame_t              frm_wd, frm_rd;

  logic                in_fire;
  logic                slot_free;
  logic [NODE_W-1:0]   in_a, in_b;
  action_t             in_act;
  logic                add_bad;
  logic                can_enter;
  logic [LOOP_W-1:0]   la_val, lb_val;

  assign n_use     = (node_count_r > NODE_MAX) ? NODE_MAX : node_count_r;
  assign in_tready = (st_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign in_a      = in_tdata[NODE_W-1:0];
  assign in_b      = in_tdata[2*NODE_W-1:NODE_W];
  assign in_act    = action_t'(in_tuser);
  assign add_bad   = ({1'b0, in_a} >= n_use) || ({1'b0, in_b} >= n_use) ||
                     (etot_r >= ELNK_W'(MAX_EDGES));
  assign can_enter = (fsp_r < NODE_MAX - CNT_W'(1)) && (nsp_r < NODE_MAX);
  assign la_val    = loopv_r[a_r] ? loop_rd : '0;
  assign lb_val    = loopv_r[b_r] ? loop_rd : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  sclf_ram #(.W(EDGE_W), .D(MAX_NODES)) u_first (
    .clk(clk), .we(first_we), .addr(first_addr), .wdata(first_wd), .rdata(first_rd));
  sclf_ram #(.W(EDGE_W), .D(MAX_NODES)) u_last (
    .clk(clk), .we(last_we), .addr(last_addr), .wdata(last_wd), .rdata(last_rd));
  sclf_ram #(.W(NODE_W), .D(MAX_EDGES)) u_tgt (
    .clk(clk), .we(tgt_we), .addr(tgt_addr), .wdata(tgt_wd), .rdata(tgt_rd));
  sclf_ram #(.W(ELNK_W), .D(MAX_EDGES)) u_nxt (
    .clk(clk), .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wd), .rdata(nxt_rd));
  sclf_ram #(.W(NODE_W), .D(MAX_NODES)) u_ord (
    .clk(clk), .we(ord_we), .addr(ord_addr), .wdata(ord_wd), .rdata(ord_rd));
  sclf_ram #(.W(LOOP_W), .D(MAX_NODES)) u_loop (
    .clk(clk), .we(loop_we), .addr(loop_addr), .wdata(loop_wd), .rdata(loop_rd));
  sclf_ram #(.W(NODE_W), .D(MAX_NODES)) u_nstk (
    .clk(clk), .we(nstk_we), .addr(nstk_addr), .wdata(nstk_wd), .rdata(nstk_rd));
  sclf_ram #(.W($bits(frame_t)), .D(MAX_NODES)) u_frm (
    .clk(clk), .we(frm_we), .addr(frm_addr), .wdata(frm_wd), .rdata(frm_rd));

  always_comb begin
    first_we   = 1'b0;
    last_we    = 1'b0;
    tgt_we     = 1'b0;
    nxt_we     = 1'b0;
    ord_we     = 1'b0;
    loop_we    = 1'b0;
    nstk_we    = 1'b0;
    frm_we     = 1'b0;
    first_addr = a_r;
    last_addr  = a_r;
    tgt_addr   = etot_r[EDGE_W-1:0];
    nxt_addr   = etot_r[EDGE_W-1:0];
    ord_addr   = ent_r;
    loop_addr  = a_r;
    nstk_addr  = nsp_r[NODE_W-1:0];
    frm_addr   = fsp_r[NODE_W-1:0];
    first_wd   = etot_r[EDGE_W-1:0];
    last_wd    = etot_r[EDGE_W-1:0];
    tgt_wd     = b_r;
    nxt_wd     = NO_EDGE;
    ord_wd     = vc_r[NODE_W-1:0];
    loop_wd    = comp_r;
    nstk_wd    = ent_r;
    frm_wd     = '{node: v_r, edge_ptr: nxt_rd, low: low_r, ord: ord_r};
    unique case (st_r)
      ST_ADD_NEW: begin
        first_we = 1'b1;
        last_we  = 1'b1;
        tgt_we   = 1'b1;
        nxt_we   = 1'b1;
      end
      ST_ADD_LINK: begin
        nxt_addr = last_rd;
        nxt_wd   = etot_r;
        nxt_we   = 1'b1;
        last_we  = 1'b1;
        tgt_we   = 1'b1;
      end
      ST_ADD_TAIL: nxt_we = 1'b1;
      ST_ROOT:     first_addr = r_r[NODE_W-1:0];
      ST_ENTER: begin
        ord_we  = 1'b1;
        nstk_we = 1'b1;
      end
      ST_LOOP: begin
        tgt_addr = e_r[EDGE_W-1:0];
        nxt_addr = e_r[EDGE_W-1:0];
      end
      ST_EDGE: begin
        first_addr = tgt_rd;
        ord_addr   = tgt_rd;
        frm_we     = ({1'b0, tgt_rd} < n_use) && !visited_r[tgt_rd] && can_enter;
      end
      ST_POP:  nstk_addr = nsp_r[NODE_W-1:0] - NODE_W'(1);
      ST_LW:   nstk_addr = k_r[NODE_W-1:0];
      ST_LW_RD: begin
        loop_addr = nstk_rd;
        loop_we   = 1'b1;
      end
      ST_FPOP: frm_addr = fsp_r[NODE_W-1:0] - NODE_W'(1);
      ST_Q_B:  loop_addr = b_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      node_count_r <= NODE_MAX;
      fvalid_r     <= '0;
      visited_r    <= '0;
      onstk_r      <= '0;
      loopv_r      <= '0;
      etot_r       <= '0;
      vc_r         <= '0;
      cc_r         <= CNT_W'(1);
      lf_r         <= '0;
      r_r          <= '0;
      fsp_r        <= '0;
      nsp_r        <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      // emit state reloads the output register itself
      if (out_valid_r && out_tready && st_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            a_r <= in_a;
            b_r <= in_b;
            unique case (in_act)
              ACT_CLEAR: begin
                fvalid_r <= '0;
                etot_r   <= '0;
              end
              ACT_ADD: begin
                if (add_bad) begin
                  res_kind_r <= KIND_EDGE_ERR;
                  res_la_r   <= '0;
                  res_lb_r   <= '0;
                  res_same_r <= 1'b0;
                  st_r       <= ST_EMIT;
                end else if (!fvalid_r[in_a]) begin
                  st_r <= ST_ADD_NEW;
                end else begin
                  st_r <= ST_ADD_RD;
                end
              end
              ACT_RUN: begin
                visited_r <= '0;
                onstk_r   <= '0;
                loopv_r   <= '0;
                vc_r      <= '0;
                cc_r      <= CNT_W'(1);
                lf_r      <= '0;
                r_r       <= '0;
                fsp_r     <= '0;
                nsp_r     <= '0;
                active_r  <= 1'b0;
                st_r      <= ST_ROOT;
              end
              ACT_QUERY: st_r <= ST_Q_A;
              default: ;
            endcase
          end
        end
        ST_ADD_NEW: begin
          fvalid_r[a_r] <= 1'b1;
          etot_r        <= etot_r + ELNK_W'(1);
          st_r          <= ST_IDLE;
        end
        ST_ADD_RD:   st_r <= ST_ADD_LINK;
        ST_ADD_LINK: st_r <= ST_ADD_TAIL;
        ST_ADD_TAIL: begin
          etot_r <= etot_r + ELNK_W'(1);
          st_r   <= ST_IDLE;
        end
        ST_ROOT: begin
          if (r_r >= n_use) begin
            res_kind_r <= KIND_DONE;
            res_la_r   <= '0;
            res_lb_r   <= '0;
            res_same_r <= 1'b0;
            st_r       <= ST_EMIT;
          end else if (visited_r[r_r[NODE_W-1:0]]) begin
            r_r <= r_r + CNT_W'(1);
          end else begin
            ent_r <= r_r[NODE_W-1:0];
            st_r  <= ST_ENTER;
          end
        end
        ST_ENTER: begin
          v_r              <= ent_r;
          e_r              <= fvalid_r[ent_r] ? {1'b0, first_rd} : NO_EDGE;
          ord_r            <= vc_r[NODE_W-1:0];
          low_r            <= vc_r[NODE_W-1:0];
          visited_r[ent_r] <= 1'b1;
          onstk_r[ent_r]   <= 1'b1;
          nsp_r            <= nsp_r + CNT_W'(1);
          vc_r             <= vc_r + CNT_W'(1);
          active_r         <= 1'b1;
          st_r             <= ST_LOOP;
        end
        ST_LOOP: begin
          if (!active_r) begin
            st_r <= ST_ROOT;
          end else if (e_r != NO_EDGE) begin
            st_r <= ST_EDGE;
          end else if (low_r == ord_r) begin
            comp_r <= cc_r;
            cc_r   <= cc_r + CNT_W'(1);
            pop1_r <= 1'b0;
            many_r <= 1'b0;
            base_r <= nsp_r;
            st_r   <= ST_POP;
          end else begin
            st_r <= ST_FPOP;
          end
        end
        ST_EDGE: begin
          e_r <= nxt_rd;
          if ({1'b0, tgt_rd} >= n_use) begin
            st_r <= ST_LOOP;
          end else if (!visited_r[tgt_rd]) begin
            if (can_enter) begin
              fsp_r <= fsp_r + CNT_W'(1);
              ent_r <= tgt_rd;
              st_r  <= ST_ENTER;
            end else begin
              st_r <= ST_LOOP;
            end
          end else if (onstk_r[tgt_rd]) begin
            st_r <= ST_ORDCHK;
          end else begin
            st_r <= ST_LOOP;
          end
        end
        ST_ORDCHK: begin
          if (ord_rd < low_r) begin
            low_r <= ord_rd;
          end
          st_r <= ST_LOOP;
        end
        ST_POP: begin
          if (nsp_r == '0) begin
            st_r <= ST_POP_DONE;
          end else begin
            nsp_r <= nsp_r - CNT_W'(1);
            st_r  <= ST_POP_RD;
          end
        end
        ST_POP_RD: begin
          onstk_r[nstk_rd] <= 1'b0;
          pop1_r           <= 1'b1;
          if (pop1_r) begin
            many_r <= 1'b1;
          end
          st_r <= (nstk_rd == v_r || nsp_r == '0) ? ST_POP_DONE : ST_POP;
        end
        ST_POP_DONE: begin
          if (many_r) begin
            lf_r <= lf_r + LCNT_W'(1);
            k_r  <= nsp_r;
            st_r <= ST_LW;
          end else begin
            st_r <= ST_FPOP;
          end
        end
        ST_LW: begin
          if (k_r == base_r) begin
            st_r <= ST_FPOP;
          end else begin
            k_r  <= k_r + CNT_W'(1);
            st_r <= ST_LW_RD;
          end
        end
        ST_LW_RD: begin
          loopv_r[nstk_rd] <= 1'b1;
          st_r             <= ST_LW;
        end
        ST_FPOP: begin
          if (fsp_r == '0) begin
            active_r <= 1'b0;
            st_r     <= ST_ROOT;
          end else begin
            fsp_r <= fsp_r - CNT_W'(1);
            st_r  <= ST_FRD;
          end
        end
        ST_FRD: begin
          // child's low link folds into the parent on return
          v_r   <= frm_rd.node;
          e_r   <= frm_rd.edge_ptr;
          ord_r <= frm_rd.ord;
          low_r <= (low_r < frm_rd.low) ? low_r : frm_rd.low;
          st_r  <= ST_LOOP;
        end
        ST_Q_A: st_r <= ST_Q_B;
        ST_Q_B: begin
          res_la_r <= la_val;
          st_r     <= ST_Q_C;
        end
        ST_Q_C: begin
          res_kind_r <= KIND_QUERY;
          res_lb_r   <= lb_val;
          res_same_r <= (res_la_r != '0) && (res_la_r == lb_val);
          st_r       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_data_r  <= {3'b000, lf_r, res_same_r, res_lb_r, res_la_r};
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !active_r)
    else $error("DFS still active while idle");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    etot_r <= ELNK_W'(MAX_EDGES))
    else $error("edge count past capacity");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (nsp_r <= NODE_MAX) && (fsp_r < NODE_MAX))
    else $error("stack pointer out of range");

  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_EMIT && !out_valid_r) |=> !out_valid_r)
    else $error("result beat raised outside emit");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && !slot_free) |=> (st_r == ST_EMIT))
    else $error("result dropped while output busy");

endmodule
